[rtl/core/mat4_vector_transform_engine_unit_macros.svh]
// Assertion macros for the mat4 vector transform engine.
`ifndef MAT4_VECTOR_TRANSFORM_ENGINE_UNIT_MACROS_SVH
`define MAT4_VECTOR_TRANSFORM_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MVTE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mvte: assertion failed");
`define MVTE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mvte: assertion failed");
`else
`define MVTE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MVTE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/core/mvte_pkg.sv]
// Shared types, mode codes and defaults for the mat4 vector transform engine.
package mvte_pkg;

  localparam int DIM_DEF       = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int VEC_N         = 4;

  typedef logic [2:0] mode_t;

  localparam mode_t MODE_LOAD    = 3'd0;
  localparam mode_t MODE_ADD_COL = 3'd1;
  localparam mode_t MODE_SUB_COL = 3'd2;
  localparam mode_t MODE_ADD_SCL = 3'd3;
  localparam mode_t MODE_SUB_SCL = 3'd4;
  localparam mode_t MODE_SCALE   = 3'd5;
  localparam mode_t MODE_MV      = 3'd6;
  localparam mode_t MODE_VM      = 3'd7;

  typedef struct packed {
    mode_t                    mode;
    logic [1:0]               column;
    logic signed [WORD_W-1:0] vec_x;
    logic signed [WORD_W-1:0] vec_y;
    logic signed [WORD_W-1:0] vec_z;
    logic signed [WORD_W-1:0] vec_w;
    logic signed [WORD_W-1:0] scalar;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] out_x;
    logic signed [WORD_W-1:0] out_y;
    logic signed [WORD_W-1:0] out_z;
    logic signed [WORD_W-1:0] out_w;
    logic                     saturated;
  } out_item_t;

  // upd: apply a matrix update this cycle; cap: capture element products
  typedef struct packed {
    logic       upd;
    logic       cap;
    mode_t      mode;
    logic [1:0] column;
  } mat_ctl_t;

endpackage

[rtl/core/mvte_matrix.sv]
// Matrix store with one multiplier per element, update logic and product registers.
module mvte_matrix
  import mvte_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mat_ctl_t                              ctl,
  input  logic signed [WORD_W-1:0]              vec [DIM],
  input  logic signed [WORD_W-1:0]              scalar,
  output logic signed [2*WORD_W-FRAC_BITS-1:0]  prod [DIM][DIM],
  output logic                                  clip
);

  localparam int PW = 2*WORD_W - FRAC_BITS;

  logic [DIM*DIM-1:0] clip_bits;

  assign clip = |clip_bits;

  for (genvar c = 0; c < DIM; c++) begin : g_col
    for (genvar r = 0; r < DIM; r++) begin : g_row
      logic signed [WORD_W-1:0]   elem;
      logic signed [PW-1:0]       p_q;
      logic signed [WORD_W-1:0]   opnd;
      logic signed [2*WORD_W-1:0] full;
      logic signed [PW-1:0]       trunc;
      logic signed [PW-1:0]       wide;
      logic                       fits;
      logic [WORD_W-1:0]          elem_next;
      logic                       col_hit;
      logic                       we;

      always_comb begin
        if (ctl.mode == MODE_MV) begin
          opnd = vec[c];
        end else if (ctl.mode == MODE_VM) begin
          opnd = vec[r];
        end else begin
          opnd = scalar;
        end
        full  = opnd * elem;
        trunc = full[2*WORD_W-1:FRAC_BITS];
        case (ctl.mode)
          MODE_LOAD:    wide = PW'(vec[r]);
          MODE_ADD_COL: wide = PW'(elem) + PW'(vec[r]);
          MODE_SUB_COL: wide = PW'(elem) - PW'(vec[r]);
          MODE_ADD_SCL: wide = PW'(elem) + PW'(scalar);
          MODE_SUB_SCL: wide = PW'(elem) - PW'(scalar);
          MODE_SCALE:   wide = trunc;
          default:      wide = PW'(elem);
        endcase
        fits = (wide[PW-1:WORD_W-1] == '0) || (wide[PW-1:WORD_W-1] == '1);
        if (fits) begin
          elem_next = wide[WORD_W-1:0];
        end else if (wide[PW-1]) begin
          elem_next = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
          elem_next = {1'b0, {(WORD_W-1){1'b1}}};
        end
        col_hit = (c < VEC_N) && (ctl.column == 2'(c));
        if (ctl.mode inside {MODE_LOAD, MODE_ADD_COL, MODE_SUB_COL}) begin
          we = ctl.upd && col_hit;
        end else if (ctl.mode inside {MODE_ADD_SCL, MODE_SUB_SCL, MODE_SCALE}) begin
          we = ctl.upd;
        end else begin
          we = 1'b0;
        end
      end

      assign clip_bits[c*DIM+r] = we && !fits;
      assign prod[c][r]         = p_q;

      always_ff @(posedge clk) begin
        if (rst) begin
          elem <= '0;
        end else if (we) begin
          elem <= elem_next;
        end
      end

      always_ff @(posedge clk) begin
        if (ctl.cap) begin
          p_q <= trunc;
        end
      end
    end
  end

endmodule

[rtl/core/mvte_lane.sv]
// One dot-product lane: sums truncated products, saturates, registers the element.
module mvte_lane
  import mvte_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic signed [2*WORD_W-FRAC_BITS-1:0] term [DIM],
  output logic signed [WORD_W-1:0]             res,
  output logic                                 clip
);

  localparam int PW = 2*WORD_W - FRAC_BITS;
  localparam int SW = PW + $clog2(DIM);

  logic signed [SW-1:0] acc;
  logic                 fits;
  logic [WORD_W-1:0]    res_next;

  always_comb begin
    acc = '0;
    for (int j = 0; j < DIM; j++) begin
      acc = acc + SW'(term[j]);
    end
    fits = (acc[SW-1:WORD_W-1] == '0) || (acc[SW-1:WORD_W-1] == '1);
    if (fits) begin
      res_next = acc[WORD_W-1:0];
    end else if (acc[SW-1]) begin
      res_next = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res_next = {1'b0, {(WORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res  <= res_next;
      clip <= !fits;
    end
  end

endmodule

[rtl/core/mat4_vector_transform_engine_unit.sv]
// Top level of the mat4 vector transform engine: pipeline control, lanes and merge.
// Holds a DIM x DIM signed Q16.16 matrix (column-major) and takes one beat per clock,
// updates included, except that a multiply beat waits while the result path stalls:
// an update is applied at the edge after its beat is taken, so the very next beat
// sees it. A multiply beat (M*v or v*M) passes the input register, the element
// product register and the lane sum register before its result is presented; the
// DIM x DIM element multipliers are shared by scaling and both multiply modes.
// Products drop FRAC_BITS low bits toward minus infinity, each sum saturates to 32
// bits and sets the saturated flag. Reset clears the matrix at once.
`include "mat4_vector_transform_engine_unit_macros.svh"

module mat4_vector_transform_engine_unit
  import mvte_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  localparam int PW = 2*WORD_W - FRAC_BITS;

  in_item_t                 a;
  logic                     a_valid;
  logic                     a_is_mul;
  logic                     a_go;
  logic                     b_valid;
  mode_t                    b_mode;
  logic                     b_go;
  logic                     b_free;
  logic                     out_free;
  logic                     sticky_overflow;
  mat_ctl_t                 ctl;
  logic                     mat_clip;
  logic signed [WORD_W-1:0] vec [DIM];
  logic signed [PW-1:0]     prod [DIM][DIM];
  logic signed [WORD_W-1:0] lane_res [DIM];
  logic [DIM-1:0]           lane_clip;
  logic signed [WORD_W-1:0] res4 [VEC_N];

  assign a_is_mul   = (a.mode == MODE_MV) || (a.mode == MODE_VM);
  assign out_free   = !result_valid || result_ready;
  assign b_go       = b_valid && out_free;
  assign b_free     = !b_valid || b_go;
  assign a_go       = a_valid && (!a_is_mul || b_free);
  assign item_ready = !a_valid || a_go;

  assign ctl.upd    = a_go && !a_is_mul;
  assign ctl.cap    = a_go && a_is_mul;
  assign ctl.mode   = a.mode;
  assign ctl.column = a.column;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid         <= 1'b0;
      b_valid         <= 1'b0;
      result_valid    <= 1'b0;
      sticky_overflow <= 1'b0;
    end else begin
      if (item_ready) begin
        a_valid <= item_valid;
      end
      if (ctl.cap) begin
        b_valid <= 1'b1;
      end else if (b_go) begin
        b_valid <= 1'b0;
      end
      if (b_go) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if ((ctl.upd && mat_clip) || (result_valid && result.saturated)) begin
        sticky_overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      a <= item;
    end
    if (ctl.cap) begin
      b_mode <= a.mode;
    end
  end

  // vector elements past the fourth read as zero
  for (genvar j = 0; j < DIM; j++) begin : g_vec
    if (j == 0) begin : g_x
      assign vec[j] = a.vec_x;
    end else if (j == 1) begin : g_y
      assign vec[j] = a.vec_y;
    end else if (j == 2) begin : g_z
      assign vec[j] = a.vec_z;
    end else if (j == 3) begin : g_w
      assign vec[j] = a.vec_w;
    end else begin : g_zero
      assign vec[j] = '0;
    end
  end

  mvte_matrix #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_matrix (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .vec    (vec),
    .scalar (a.scalar),
    .prod   (prod),
    .clip   (mat_clip)
  );

  for (genvar i = 0; i < DIM; i++) begin : g_lane
    logic signed [PW-1:0] term [DIM];

    // M*v takes row i of the products, v*M takes column i
    for (genvar j = 0; j < DIM; j++) begin : g_term
      assign term[j] = (b_mode == MODE_MV) ? prod[j][i] : prod[i][j];
    end

    mvte_lane #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .load (b_go),
      .term (term),
      .res  (lane_res[i]),
      .clip (lane_clip[i])
    );
  end

  for (genvar i = 0; i < VEC_N; i++) begin : g_merge
    if (i < DIM) begin : g_live
      assign res4[i] = lane_res[i];
    end else begin : g_pad
      assign res4[i] = '0;
    end
  end

  assign result.out_x     = res4[0];
  assign result.out_y     = res4[1];
  assign result.out_z     = res4[2];
  assign result.out_w     = res4[3];
  assign result.saturated = |lane_clip;

  `MVTE_ASSERT_NEXT(a_sat_sets_sticky, clk, rst, result_valid && result.saturated, sticky_overflow)
  `MVTE_ASSERT_IMPL(a_sticky_holds, clk, rst, !$past(rst), !$fell(sticky_overflow))
  `MVTE_ASSERT_NEXT(a_prod_held, clk, rst, b_valid && !out_free, b_valid)
  `MVTE_ASSERT_IMPL(a_prod_is_mul, clk, rst, b_valid, b_mode == MODE_MV || b_mode == MODE_VM)

endmodule
